/* rtl/sse2enc_pkg.sv */
// shared types, byte constants and sequence helpers for the scalar-double encoder
package sse2enc_pkg;

   // request operation codes
   localparam logic [3:0] OP_LOAD_RDI  = 4'd0;
   localparam logic [3:0] OP_STORE_RDI = 4'd1;
   localparam logic [3:0] OP_LOAD_ABS  = 4'd2;
   localparam logic [3:0] OP_STORE_ABS = 4'd3;
   localparam logic [3:0] OP_MOV_RR    = 4'd4;
   localparam logic [3:0] OP_ADD       = 4'd5;
   localparam logic [3:0] OP_SUB       = 4'd6;
   localparam logic [3:0] OP_MUL       = 4'd7;
   localparam logic [3:0] OP_DIV       = 4'd8;
   localparam logic [3:0] OP_PUSH      = 4'd9;
   localparam logic [3:0] OP_POP       = 4'd10;
   localparam logic [3:0] OP_RET       = 4'd11;

   // fixed machine-code bytes
   localparam logic [7:0] BYTE_F2     = 8'hf2;
   localparam logic [7:0] BYTE_0F     = 8'h0f;
   localparam logic [7:0] BYTE_REX_W  = 8'h48;
   localparam logic [7:0] BYTE_REX    = 8'h40;
   localparam logic [7:0] BYTE_MOV_SI = 8'hbe;
   localparam logic [7:0] BYTE_GRP1   = 8'h83;
   localparam logic [7:0] BYTE_SUB_SP = 8'hec;
   localparam logic [7:0] BYTE_ADD_SP = 8'hc4;
   localparam logic [7:0] BYTE_SIXTN  = 8'h10;
   localparam logic [7:0] BYTE_SIB_SP = 8'h24;
   localparam logic [7:0] BYTE_RET    = 8'hc3;
   localparam logic [7:0] OPC_LOAD    = 8'h10;
   localparam logic [7:0] OPC_STORE   = 8'h11;
   localparam logic [7:0] OPC_ADD     = 8'h58;
   localparam logic [7:0] OPC_SUB     = 8'h5c;
   localparam logic [7:0] OPC_MUL     = 8'h59;
   localparam logic [7:0] OPC_DIV     = 8'h5e;
   localparam logic [7:0] MODRM_RDI   = 8'h47;
   localparam logic [7:0] MODRM_RSI   = 8'h06;
   localparam logic [7:0] MODRM_SIB   = 8'h04;
   localparam logic [7:0] MODRM_REG   = 8'hc0;

   // shape of the byte sequence for one word
   typedef enum logic [2:0] {
      KIND_RDI  = 3'd0,
      KIND_ABS  = 3'd1,
      KIND_SSE  = 3'd2,
      KIND_PUSH = 3'd3,
      KIND_POP  = 3'd4,
      KIND_RET  = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  rex;
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      logic [7:0]  disp;
      logic [63:0] addr;
   } desc_type;

   // byte count of each sequence shape
   function automatic logic [3:0] seq_len(input kind_type kind);
      logic [3:0] len;
      unique case (kind)
         KIND_RDI:  len = 4'd6;
         KIND_ABS:  len = 4'd15;
         KIND_SSE:  len = 4'd5;
         KIND_PUSH: len = 4'd10;
         KIND_POP:  len = 4'd10;
         KIND_RET:  len = 4'd1;
         default:   len = 4'd1;
      endcase
      return len;
   endfunction

endpackage

/* rtl/sse2enc_front.sv */
// front end: takes a request word and classifies it into a sequence descriptor
module sse2enc_front (
   input  logic                 start,
   input  logic                 full,
   input  logic [3:0]           req_operation,
   input  logic [3:0]           req_xmm_a,
   input  logic [3:0]           req_xmm_b,
   input  logic [7:0]           req_disp_byte,
   input  logic [63:0]          req_mem_address,
   output logic                 push,
   output sse2enc_pkg::desc_type desc
);
   import sse2enc_pkg::*;

   logic known;
   logic [3:0] reg_no;
   logic [3:0] rm_no;

   always_comb begin
      known       = 1'b1;
      reg_no      = req_xmm_a;
      rm_no       = 4'd0;
      desc.kind   = KIND_RET;
      desc.opcode = OPC_STORE;
      desc.modrm  = MODRM_REG;
      desc.disp   = req_disp_byte;
      desc.addr   = req_mem_address;
      unique case (req_operation)
         OP_LOAD_RDI, OP_STORE_RDI: begin
            desc.kind   = KIND_RDI;
            desc.opcode = (req_operation == OP_LOAD_RDI) ? OPC_LOAD : OPC_STORE;
            desc.modrm  = MODRM_RDI;
         end
         OP_LOAD_ABS, OP_STORE_ABS: begin
            desc.kind   = KIND_ABS;
            desc.opcode = (req_operation == OP_LOAD_ABS) ? OPC_LOAD : OPC_STORE;
            desc.modrm  = MODRM_RSI;
         end
         OP_MOV_RR: begin
            desc.kind   = KIND_SSE;
            rm_no       = req_xmm_b;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            // arithmetic: destination in reg, source in rm
            desc.kind = KIND_SSE;
            reg_no    = req_xmm_b;
            rm_no     = req_xmm_a;
            unique case (req_operation)
               OP_ADD:  desc.opcode = OPC_ADD;
               OP_SUB:  desc.opcode = OPC_SUB;
               OP_MUL:  desc.opcode = OPC_MUL;
               default: desc.opcode = OPC_DIV;
            endcase
         end
         OP_PUSH: begin
            desc.kind   = KIND_PUSH;
            desc.modrm  = MODRM_SIB;
         end
         OP_POP: begin
            desc.kind   = KIND_POP;
            desc.opcode = OPC_LOAD;
            desc.modrm  = MODRM_SIB;
         end
         OP_RET: desc.kind = KIND_RET;
         default: known = 1'b0;
      endcase
      desc.rex   = BYTE_REX | {5'd0, reg_no[3], 1'b0, rm_no[3]};
      desc.modrm = desc.modrm | {2'd0, reg_no[2:0], rm_no[2:0]};
   end

   // unknown codes are taken but produce nothing
   assign push = start && !full && known;

endmodule

/* rtl/sse2enc_queue.sv */
// short descriptor queue between the front and back ends
module sse2enc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sse2enc_pkg::desc_type push_desc,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output sse2enc_pkg::desc_type head_desc
);
   import sse2enc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_desc = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

/* rtl/sse2enc_back.sv */
// back end: walks a descriptor and emits one code byte per cycle
module sse2enc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  sse2enc_pkg::desc_type head_desc,
   output logic                 pop,
   output logic                 rsp_strobe,
   output logic [7:0]           rsp_code_byte,
   output logic                 rsp_last_byte
);
   import sse2enc_pkg::*;

   desc_type   cur_ff;
   logic       active_ff, active_in;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] len;
   logic       finishing;
   logic [7:0] byte_sel;
   logic [3:0] addr_idx;
   logic [7:0] addr_byte;
   logic       strobe_ff;
   logic [7:0] code_ff;
   logic       last_ff;

   // byte of the F2 REX 0F opcode ModRM block
   function automatic logic [7:0] sse_byte(input logic [3:0] pos, input desc_type d);
      logic [7:0] b;
      unique case (pos)
         4'd0:    b = BYTE_F2;
         4'd1:    b = d.rex;
         4'd2:    b = BYTE_0F;
         4'd3:    b = d.opcode;
         default: b = d.modrm;
      endcase
      return b;
   endfunction

   assign len       = seq_len(cur_ff.kind);
   assign finishing = active_ff && (idx_ff == len - 4'd1);
   assign pop       = not_empty && (!active_ff || finishing);
   assign addr_idx  = idx_ff - 4'd2;
   assign addr_byte = 8'(cur_ff.addr >> {addr_idx[2:0], 3'b000});

   always_comb begin
      byte_sel = BYTE_RET;
      unique case (cur_ff.kind)
         KIND_RDI:  byte_sel = (idx_ff < 4'd5) ? sse_byte(idx_ff, cur_ff) : cur_ff.disp;
         KIND_ABS: begin
            if (idx_ff == 4'd0)      byte_sel = BYTE_REX_W;
            else if (idx_ff == 4'd1) byte_sel = BYTE_MOV_SI;
            else if (idx_ff < 4'd10) byte_sel = addr_byte;
            else                     byte_sel = sse_byte(idx_ff - 4'd10, cur_ff);
         end
         KIND_SSE:  byte_sel = sse_byte(idx_ff, cur_ff);
         KIND_PUSH: begin
            unique case (idx_ff)
               4'd0:    byte_sel = BYTE_REX_W;
               4'd1:    byte_sel = BYTE_GRP1;
               4'd2:    byte_sel = BYTE_SUB_SP;
               4'd3:    byte_sel = BYTE_SIXTN;
               4'd9:    byte_sel = BYTE_SIB_SP;
               default: byte_sel = sse_byte(idx_ff - 4'd4, cur_ff);
            endcase
         end
         KIND_POP: begin
            unique case (idx_ff)
               4'd5:    byte_sel = BYTE_SIB_SP;
               4'd6:    byte_sel = BYTE_REX_W;
               4'd7:    byte_sel = BYTE_GRP1;
               4'd8:    byte_sel = BYTE_ADD_SP;
               4'd9:    byte_sel = BYTE_SIXTN;
               default: byte_sel = sse_byte(idx_ff, cur_ff);
            endcase
         end
         default:   byte_sel = BYTE_RET;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      if (pop) begin
         active_in = 1'b1;
         idx_in    = 4'd0;
      end else if (finishing) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 4'd0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         strobe_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_desc;
      end
      code_ff <= byte_sel;
      last_ff <= finishing;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_code_byte = code_ff;
   assign rsp_last_byte = strobe_ff && last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff < len))
      else $error("byte index past end of sequence");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (finishing && !pop) |=> !active_ff)
      else $error("emitter still active after last byte");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      active_ff |=> rsp_strobe)
      else $error("active cycle produced no byte");

endmodule

/* rtl/sse2_scalar_double_encoder_top.sv */
// top level of the x86-64 scalar-double instruction encoder
//
//  channel   direction  handshake                 payload
//  request   in         start && !busy            req_operation, req_xmm_a, req_xmm_b,
//                                                 req_disp_byte, req_mem_address
//  response  out        rsp_strobe (one cycle)    rsp_code_byte, rsp_last_byte
//
// - each known word yields 1 to 15 code bytes, one byte per cycle from the back end;
//   the byte count per sequence: ret 1, reg ops 5, rdi moves 6, push/pop 10,
//   absolute moves 15
// - when the back end was idle, a word goes through the queue, the back end's descriptor
//   register and its output registers; queued words follow with no gap between their byte runs
// - busy is high while the descriptor queue is full; unknown operation codes are
//   accepted and emit nothing
// - reset is synchronous and clears the queue and emitter; the receiver cannot stall
module sse2_scalar_double_encoder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_operation,
   input  logic [3:0]  req_xmm_a,
   input  logic [3:0]  req_xmm_b,
   input  logic [7:0]  req_disp_byte,
   input  logic [63:0] req_mem_address,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_last_byte
);
   import sse2enc_pkg::*;

   // front end to queue
   logic     push;
   desc_type push_desc;
   // queue to back end
   logic     full;
   logic     not_empty;
   logic     pop;
   desc_type head_desc;

   // classify the request word into a sequence descriptor
   sse2enc_front u_front (
      .start           (start),
      .full            (full),
      .req_operation   (req_operation),
      .req_xmm_a       (req_xmm_a),
      .req_xmm_b       (req_xmm_b),
      .req_disp_byte   (req_disp_byte),
      .req_mem_address (req_mem_address),
      .push            (push),
      .desc            (push_desc)
   );

   // decouples acceptance from byte emission
   sse2enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_desc (head_desc)
   );

   // walks each descriptor and drives the registered response
   sse2enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .not_empty     (not_empty),
      .head_desc     (head_desc),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   // new words are held off only while the queue has no free slot
   assign busy = full;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench for the scalar-double instruction encoder: directed and random words, byte checker
module tb;
   import sse2enc_pkg::*;

   // operation codes past ret are accepted but emit no bytes
   localparam logic [3:0] OP_FIRST_UNUSED = 4'd12;
   localparam logic [3:0] OP_LAST_CODE    = 4'd15;

   // rex extension bits for the modrm reg and rm fields
   localparam logic [7:0] REX_R = 8'h04;
   localparam logic [7:0] REX_B = 8'h01;

   // random part size, in words that produce bytes
   localparam int RANDOM_WORDS = 288;
   localparam int MAX_REPORTS  = 10;
   // cycles allowed for the byte stream to drain, then quiet cycles to catch strays
   localparam int DRAIN_LIMIT  = 4000;
   localparam int QUIET_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_operation;
   logic [3:0]  req_xmm_a;
   logic [3:0]  req_xmm_b;
   logic [7:0]  req_disp_byte;
   logic [63:0] req_mem_address;
   logic        rsp_strobe;
   logic [7:0]  rsp_code_byte;
   logic        rsp_last_byte;

   // one expected code byte, tagged with the word that produced it
   typedef struct {
      logic [7:0] code;
      logic       last;
      int         word;
   } code_byte_type;

   code_byte_type pending_bytes[$];   // expected bytes, oldest first
   logic [7:0]    word_bytes[$];      // scratch: byte sequence of the word being encoded
   int            words_accepted;
   int            mismatch_count;
   int            failure_count;
   bit            steady_stream;      // when set, the sender puts no gaps between words

   sse2_scalar_double_encoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_xmm_a       (req_xmm_a),
      .req_xmm_b       (req_xmm_b),
      .req_disp_byte   (req_disp_byte),
      .req_mem_address (req_mem_address),
      .rsp_strobe      (rsp_strobe),
      .rsp_code_byte   (rsp_code_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // encoding predictor
   // ------------------------------------------------------------------

   function automatic void append_code(input logic [7:0] value);
      word_bytes.insert(word_bytes.size(), value);
   endfunction

   // f2 rex 0f opcode modrm; reg goes to modrm.reg, rm to modrm.rm when used
   function automatic void append_sse(input logic [7:0] opcode, input logic [7:0] modbase,
                                      input logic [3:0] reg_no, input logic [3:0] rm_no,
                                      input logic use_rm);
      logic [7:0] rex;
      logic [7:0] modrm;
      rex   = BYTE_REX;
      modrm = modbase | {2'b00, reg_no[2:0], 3'b000};
      if (reg_no[3])
         rex = rex | REX_R;
      if (use_rm) begin
         if (rm_no[3])
            rex = rex | REX_B;
         modrm = modrm | {5'b00000, rm_no[2:0]};
      end
      append_code(BYTE_F2);
      append_code(rex);
      append_code(BYTE_0F);
      append_code(opcode);
      append_code(modrm);
   endfunction

   // sub/add rsp, 16 around the stack spill
   function automatic void append_rsp_adjust(input logic [7:0] modrm);
      append_code(BYTE_REX_W);
      append_code(BYTE_GRP1);
      append_code(modrm);
      append_code(BYTE_SIXTN);
   endfunction

   // works out the byte run of one accepted word and queues it
   function automatic void encode_request(input logic [3:0] op, input logic [3:0] xmm_a,
                                          input logic [3:0] xmm_b, input logic [7:0] disp,
                                          input logic [63:0] addr);
      code_byte_type entry;
      word_bytes.delete();
      case (op)
         OP_LOAD_RDI, OP_STORE_RDI: begin
            append_sse((op == OP_LOAD_RDI) ? OPC_LOAD : OPC_STORE, MODRM_RDI,
                       xmm_a, 4'd0, 1'b0);
            append_code(disp);
         end
         OP_LOAD_ABS, OP_STORE_ABS: begin
            // mov rsi, imm64 with the address little-endian
            append_code(BYTE_REX_W);
            append_code(BYTE_MOV_SI);
            for (int i = 0; i < 8; i++)
               append_code(addr[8*i +: 8]);
            append_sse((op == OP_LOAD_ABS) ? OPC_LOAD : OPC_STORE, MODRM_RSI,
                       xmm_a, 4'd0, 1'b0);
         end
         // movsd reg-reg: source in reg, destination in rm
         OP_MOV_RR: append_sse(OPC_STORE, MODRM_REG, xmm_a, xmm_b, 1'b1);
         // arithmetic: destination in reg, source in rm
         OP_ADD:    append_sse(OPC_ADD, MODRM_REG, xmm_b, xmm_a, 1'b1);
         OP_SUB:    append_sse(OPC_SUB, MODRM_REG, xmm_b, xmm_a, 1'b1);
         OP_MUL:    append_sse(OPC_MUL, MODRM_REG, xmm_b, xmm_a, 1'b1);
         OP_DIV:    append_sse(OPC_DIV, MODRM_REG, xmm_b, xmm_a, 1'b1);
         OP_PUSH: begin
            append_rsp_adjust(BYTE_SUB_SP);
            append_sse(OPC_STORE, MODRM_SIB, xmm_a, 4'd0, 1'b0);
            append_code(BYTE_SIB_SP);
         end
         OP_POP: begin
            append_sse(OPC_LOAD, MODRM_SIB, xmm_a, 4'd0, 1'b0);
            append_code(BYTE_SIB_SP);
            append_rsp_adjust(BYTE_ADD_SP);
         end
         OP_RET:    append_code(BYTE_RET);
         default: ;   // unknown codes emit nothing
      endcase
      for (int i = 0; i < word_bytes.size(); i++) begin
         entry.code = word_bytes[i];
         entry.last = (i == word_bytes.size() - 1);
         entry.word = words_accepted;
         pending_bytes.insert(pending_bytes.size(), entry);
      end
   endfunction

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------

   // inputs change on the falling edge; start stays high across back-to-back words
   task automatic send_word(input logic [3:0] op, input logic [3:0] xmm_a,
                            input logic [3:0] xmm_b, input logic [7:0] disp,
                            input logic [63:0] addr);
      int gap;
      gap = steady_stream ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           = 1'b1;
      req_operation   = op;
      req_xmm_a       = xmm_a;
      req_xmm_b       = xmm_b;
      req_disp_byte   = disp;
      req_mem_address = addr;
      // the word is taken at the first rising edge with busy low
      do
         @(posedge clock);
      while (busy !== 1'b0);
      encode_request(op, xmm_a, xmm_b, disp, addr);
      words_accepted++;
   endtask

   // ------------------------------------------------------------------
   // byte checker: every strobe must match the oldest expected byte
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      code_byte_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_bytes.size() == 0) begin
            failure_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected byte %02h last %b at %0t",
                        rsp_code_byte, rsp_last_byte, $realtime);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_code_byte !== want.code || rsp_last_byte !== want.last) begin
               failure_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("word %0d: expected byte %02h last %b, got %02h last %b",
                           want.word, want.code, want.last, rsp_code_byte, rsp_last_byte);
            end
         end
      end else if (!reset && rsp_strobe !== 1'b0) begin
         // strobe must never float once out of reset
         failure_count++;
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("strobe unknown at %0t", $realtime);
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // rdi-relative moves: register and displacement extremes
   task automatic test_rdi_moves;
      send_word(OP_LOAD_RDI,  4'd0,  4'd9, 8'h00, 64'd0);
      send_word(OP_STORE_RDI, 4'd15, 4'd0, 8'hff, '1);
      send_word(OP_LOAD_RDI,  4'd8,  4'd3, 8'h80, 64'd0);
      send_word(OP_STORE_RDI, 4'd7,  4'd15, 8'h7f, 64'h5555_aaaa_5555_aaaa);
   endtask

   // absolute moves: address all zeros, all ones and a byte-order pattern
   task automatic test_abs_moves;
      send_word(OP_LOAD_ABS,  4'd15, 4'd0,  8'h00, 64'd0);
      send_word(OP_STORE_ABS, 4'd0,  4'd15, 8'hff, '1);
      send_word(OP_LOAD_ABS,  4'd8,  4'd7,  8'h5a, 64'h0123_4567_89ab_cdef);
   endtask

   // register-register move and the four arithmetic ops, both rex bits each way
   task automatic test_register_ops;
      send_word(OP_MOV_RR, 4'd15, 4'd0,  8'hff, 64'd0);
      send_word(OP_MOV_RR, 4'd0,  4'd15, 8'h00, '1);
      send_word(OP_ADD,    4'd15, 4'd15, 8'h00, 64'd0);
      send_word(OP_SUB,    4'd0,  4'd0,  8'hff, '1);
      send_word(OP_MUL,    4'd8,  4'd7,  8'h12, 64'd0);
      send_word(OP_DIV,    4'd7,  4'd8,  8'h34, 64'd0);
   endtask

   // stack spill and reload
   task automatic test_stack_ops;
      send_word(OP_PUSH, 4'd15, 4'd0,  8'h00, 64'd0);
      send_word(OP_PUSH, 4'd0,  4'd15, 8'hff, '1);
      send_word(OP_POP,  4'd8,  4'd0,  8'h00, 64'd0);
      send_word(OP_POP,  4'd7,  4'd15, 8'hff, '1);
   endtask

   // ret, then every unknown code with the unused fields loaded
   task automatic test_ret_and_unknown;
      send_word(OP_RET, 4'd15, 4'd15, 8'hff, '1);
      for (int code = OP_FIRST_UNUSED; code <= OP_LAST_CODE; code++)
         send_word(code[3:0], 4'd15, 4'd15, 8'hff, '1);
      // a real word right after the unknowns shows none of them left bytes behind
      send_word(OP_RET, 4'd0, 4'd0, 8'h00, 64'd0);
   endtask

   // random words; gapless stretches are mixed with stretches of random sender gaps
   task automatic test_random_words;
      int         emitting;
      int         round;
      logic [3:0] op;
      emitting = 0;
      round    = 0;
      while (emitting < RANDOM_WORDS) begin
         if (round % 24 == 0)
            steady_stream = ($urandom_range(0, 3) == 0);
         // a few unknown codes mixed in as noise
         if ($urandom_range(0, 19) == 0)
            op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
         else
            op = 4'($urandom_range(OP_LOAD_RDI, OP_RET));
         send_word(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   8'($urandom_range(0, 255)), {$urandom, $urandom});
         if (op <= OP_RET)
            emitting++;
         round++;
      end
      steady_stream = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      int waited;
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_RET;
      req_xmm_a       = 4'd0;
      req_xmm_b       = 4'd0;
      req_disp_byte   = 8'd0;
      req_mem_address = 64'd0;
      words_accepted  = 0;
      mismatch_count  = 0;
      failure_count   = 0;
      steady_stream   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_rdi_moves();
      test_abs_moves();
      test_register_ops();
      test_stack_ops();
      test_ret_and_unknown();
      test_random_words();

      @(negedge clock);
      start = 1'b0;

      // let the byte stream drain, then watch for stray bytes
      waited = 0;
      while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         failure_count++;
         $display("%0d expected bytes never arrived, first from word %0d",
                  pending_bytes.size(), pending_bytes[0].word);
      end

      if (failure_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d bytes outstanding", pending_bytes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
